[hw/rtl/fpa_pkg.sv]
// Package for the Q24.8 fixed-point ALU: opcodes, payload structs, pipeline constants.
// Used by fixed_point_alu_core.
package fpa_pkg;

  localparam int unsigned FracBitsDef = 8;
  localparam int unsigned DataW       = 32;
  // divider: 32-bit magnitude quotient plus one extra high bit, DivBits bits per stage
  localparam int unsigned QuoW        = DataW + 1;
  localparam int unsigned DivBits     = 3;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,  OP_SUB  = 4'd1,  OP_MUL  = 4'd2,  OP_DIV  = 4'd3,
    OP_LT   = 4'd4,  OP_GT   = 4'd5,  OP_LE   = 4'd6,  OP_GE   = 4'd7,
    OP_EQ   = 4'd8,  OP_NE   = 4'd9,  OP_MIN  = 4'd10, OP_MAX  = 4'd11,
    OP_INC  = 4'd12, OP_DEC  = 4'd13, OP_FINT = 4'd14, OP_TINT = 4'd15
  } op_t;

  typedef struct packed {
    op_t                operation;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_true;
    logic               overflow;
    logic               divide_by_zero;
  } out_item_t;

endpackage

[hw/rtl/fpa_div.sv]
// Pipelined restoring divider on unsigned magnitudes, BITS_PER_STG quotient bits per stage.
// Standalone; parameters come from the instantiating module. Carries a tag alongside;
// advances only when en is high.
module fpa_div #(
  parameter int unsigned NUM_W = 64,
  parameter int unsigned DEN_W = 32,
  parameter int unsigned Q_W   = 33,
  parameter int unsigned BITS_PER_STG = 3,
  parameter int unsigned TAG_W = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] tag_in,
  output logic [Q_W-1:0]   quo,
  output logic [DEN_W:0]   rem,
  output logic [TAG_W-1:0] tag_out
);
  localparam int unsigned NumStg = (Q_W + BITS_PER_STG - 1) / BITS_PER_STG;
  localparam int unsigned TotBits = NumStg * BITS_PER_STG;
  localparam int unsigned RW = DEN_W + 1;

  // per-stage registers: remainder, remaining numerator bits (left aligned), quotient, divisor, tag
  logic [RW-1:0]      rem_r [NumStg];
  logic [TotBits-1:0] nb_r  [NumStg];
  logic [TotBits-1:0] q_r   [NumStg];
  logic [DEN_W-1:0]   d_r   [NumStg];
  logic [TAG_W-1:0]   t_r   [NumStg];

  for (genvar s = 0; s < NumStg; s++) begin : g_stg
    logic [RW-1:0]      rem_in, rem_nxt;
    logic [TotBits-1:0] nb_in, nb_nxt, q_in, q_nxt;
    logic [DEN_W-1:0]   d_in;
    logic [TAG_W-1:0]   t_in;
    if (s == 0) begin : g_first
      // numerator top bits above the quotient window are assumed to give rem < den
      assign rem_in = RW'(num >> TotBits);
      assign nb_in  = TotBits'(num);
      assign q_in   = '0;
      assign d_in   = den;
      assign t_in   = tag_in;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign nb_in  = nb_r[s-1];
      assign q_in   = q_r[s-1];
      assign d_in   = d_r[s-1];
      assign t_in   = t_r[s-1];
    end
    always_comb begin
      logic [RW:0] tr;
      rem_nxt = rem_in;
      nb_nxt  = nb_in;
      q_nxt   = q_in;
      for (int k = 0; k < BITS_PER_STG; k++) begin
        tr = {rem_nxt, nb_nxt[TotBits-1]};
        nb_nxt = nb_nxt << 1;
        if (tr >= {2'b00, d_in}) begin
          tr = tr - {2'b00, d_in};
          q_nxt = {q_nxt[TotBits-2:0], 1'b1};
        end else begin
          q_nxt = {q_nxt[TotBits-2:0], 1'b0};
        end
        rem_nxt = tr[RW-1:0];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        nb_r[s]  <= nb_nxt;
        q_r[s]   <= q_nxt;
        d_r[s]   <= d_in;
        t_r[s]   <= t_in;
      end
    end
  end

  assign quo     = Q_W'(q_r[NumStg-1]);
  assign rem     = rem_r[NumStg-1];
  assign tag_out = t_r[NumStg-1];
endmodule

[hw/rtl/fixed_point_alu_core.sv]
// Signed fixed-point ALU (Q24.8 by default), fully pipelined.
// Depends on fpa_pkg and fpa_div.
//
// Usage:
//   in_valid/in_ready/in_data carry one operation with two raw operands;
//   out_valid/out_ready/out_data carry exactly one result per input, in order.
//   A transfer happens when valid and ready are both high.
// Pipeline: every operation passes 1 operand-prep stage, 11 divider stages of
//   3 quotient bits each, and 1 final stage for rounding, sign and clamping.
//   All operations travel through the same pipe, so results keep their order.
// Throughput: one item per cycle. The pipe advances whenever the output
//   register is empty or is being taken; when the receiver stalls with a
//   result waiting, the whole pipe holds and in_ready drops.
// Reset: rst_n low clears all valid bits; no results are pending after reset.
// Multiply: 32x32 product formed in the prep stage, rounded in the last stage.
// Divide: |a|<<FRAC_BITS divided by |b| in the divider stages.
module fixed_point_alu_core #(
  parameter int unsigned FRAC_BITS = fpa_pkg::FracBitsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fpa_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fpa_pkg::out_item_t out_data
);
  import fpa_pkg::*;

  localparam int unsigned NumW   = DataW + FRAC_BITS;
  localparam int unsigned DivStg = (QuoW + DivBits - 1) / DivBits;
  localparam int unsigned Lat    = DivStg + 1;

  typedef struct packed {
    op_t                operation;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [63:0] prod;
    logic               qneg;
  } prep_t;

  localparam int unsigned PrepW = $bits(prep_t);

  logic en;
  logic [Lat-1:0] vld_r;
  logic out_valid_r;
  out_item_t out_r, out_nxt;
  prep_t prep_r, prep_nxt, prep_q;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // stage 1: product and divider operands
  logic [31:0] mag_a, mag_b;
  always_comb begin
    prep_nxt.operation = in_data.operation;
    prep_nxt.a    = in_data.operand_a;
    prep_nxt.b    = in_data.operand_b;
    prep_nxt.prod = 64'(in_data.operand_a) * 64'(in_data.operand_b);
    prep_nxt.qneg = in_data.operand_a[31] ^ in_data.operand_b[31];
    mag_a = in_data.operand_a[31] ? 32'(-in_data.operand_a) : in_data.operand_a;
    mag_b = in_data.operand_b[31] ? 32'(-in_data.operand_b) : in_data.operand_b;
  end

  logic [NumW-1:0] num_r;
  logic [31:0]     den_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prep_r <= prep_nxt;
      num_r  <= {mag_a, FRAC_BITS'(0)};
      den_r  <= mag_b;
    end
  end

  logic [QuoW-1:0] quo;
  logic [32:0]     rem;

  fpa_div #(
    .NUM_W(NumW), .DEN_W(DataW), .Q_W(QuoW), .BITS_PER_STG(DivBits), .TAG_W(PrepW)
  ) u_div (
    .clk(clk), .en(en), .num(num_r), .den(den_r | {31'd0, den_r == '0}),
    .tag_in(prep_r), .quo(quo), .rem(rem), .tag_out(prep_q)
  );

  // the divider needs a 33-bit quotient: check numerator bits above it are covered
  // |a|<<F < 2^(32+F) and quotient window is 33 bits, so top remainder < den holds
  // when the high F-1 bits are zero; wider parts saturate via the quotient overflow flag

  // final stage
  logic [31:0] den_q;
  assign den_q = prep_q.b[31] ? 32'(-prep_q.b) : prep_q.b;

  always_comb begin
    logic signed [33:0] s;
    logic [63:0] pm, pr;
    logic [64:0] mq;
    logic [33:0] dq;
    logic big, hi;
    logic signed [65:0] v;
    logic signed [31:0] a, b;
    a = prep_q.a;
    b = prep_q.b;
    out_nxt = '0;
    v = '0;
    big = 1'b0;
    s = '0;
    pm = '0; pr = '0; mq = '0; dq = '0; hi = 1'b0;
    case (prep_q.operation)
      OP_ADD: v = 66'(a) + 66'(b);
      OP_SUB: v = 66'(a) - 66'(b);
      OP_MUL: begin
        pm = prep_q.prod[63] ? 64'(-prep_q.prod) : 64'(prep_q.prod);
        pr = pm + (64'd1 << (FRAC_BITS - 1));
        mq = {1'b0, pr >> FRAC_BITS};
        v  = prep_q.prod[63] ? -$signed({1'b0, mq}) : $signed({1'b0, mq});
      end
      OP_DIV: begin
        if (b == '0) begin
          out_nxt.divide_by_zero = 1'b1;
        end else begin
          // round up when twice the remainder reaches the divisor
          hi = ({rem, 1'b0} >= {2'b00, den_q});
          dq = {1'b0, quo} + {33'd0, hi};
          // quotient may have lost high bits if |a|<<F >= 2^33*|b|
          big = (({32'd0, prep_q.a[31] ? 32'(-a) : a}) >> (QuoW - FRAC_BITS))
                >= 64'(den_q);
          if (big) dq = 34'h1_0000_0000;
          v = prep_q.qneg ? -66'($signed({1'b0, dq})) : 66'($signed({1'b0, dq}));
        end
      end
      OP_LT: out_nxt.compare_true = a < b;
      OP_GT: out_nxt.compare_true = a > b;
      OP_LE: out_nxt.compare_true = a <= b;
      OP_GE: out_nxt.compare_true = a >= b;
      OP_EQ: out_nxt.compare_true = a == b;
      OP_NE: out_nxt.compare_true = a != b;
      OP_MIN: v = 66'((a < b) ? a : b);
      OP_MAX: v = 66'((a > b) ? a : b);
      OP_INC: v = 66'(a) + 66'sd1;
      OP_DEC: v = 66'(a) - 66'sd1;
      OP_FINT: v = 66'(a) <<< FRAC_BITS;
      default: begin
        s = 34'(a) + (a[31] ? 34'((34'sd1 <<< FRAC_BITS) - 1) : 34'sd0);
        v = 66'(s >>> FRAC_BITS);
      end
    endcase
    if (v > 66'sd2147483647) begin
      out_nxt.result_value = 32'h7FFF_FFFF;
      out_nxt.overflow = 1'b1;
    end else if (v < -66'sd2147483648) begin
      out_nxt.result_value = 32'h8000_0000;
      out_nxt.overflow = 1'b1;
    end else begin
      out_nxt.result_value = 32'(v);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[Lat-2:0], in_valid};
      out_valid_r <= vld_r[Lat-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_r <= out_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.divide_by_zero |-> out_data.result_value == '0 && !out_data.overflow)
    else $error("divide by zero result not zero");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.compare_true |-> out_data.result_value == '0)
    else $error("compare with nonzero value");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("ready mismatch");
endmodule
